>>> sv/ekf_mj_pkg.sv
// Shared types, constants and arithmetic helpers of the motion Jacobian block.
package ekf_mj_pkg;

  // Entry stream
  localparam int ENTRY_COUNT = 32;
  localparam int CNT_W       = 5;

  // Series lengths of the sine and cosine evaluation
  localparam int TERM_COUNT = 8;
  localparam int SIN_TERMS  = 7;

  // Stage counts: front reduction, three stages per series term, final quadrant stage
  localparam int TRIG_LAT = 6 + 3 * TERM_COUNT + 1;
  localparam int ROT_LAT  = 6;

  localparam logic [15:0] TIME_STEP_RESET = 16'd655;

  // pi/2 in Q.40 and its half, plus a reciprocal for quotient estimation
  localparam logic [40:0] HALF_PI_Q40  = 41'd1727108826179;
  localparam logic [39:0] QTR_PI_Q40   = 40'(HALF_PI_Q40 / 2);
  localparam logic [15:0] REDUCE_RECIP = 16'((65'd1 << 56) / HALF_PI_Q40);

  localparam logic signed [63:0] SAT_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] SAT_MIN = -64'sd140737488355328;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [33:0] coef_t;
  typedef logic signed [47:0] entry_t;

  localparam entry_t ONE_Q24 = 48'sd16777216;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] yaw_rate;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         row;
    logic [3:0]         column;
    logic signed [47:0] entry_value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pos_t;

  typedef struct packed {
    q30_t sr;
    q30_t cr;
    q30_t sp;
    q30_t cp;
    q30_t sy;
    q30_t cy;
  } sincos_t;

  localparam logic [3:0] ENTRY_ROW [ENTRY_COUNT] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11
  };

  localparam logic [3:0] ENTRY_COL [ENTRY_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd6, 4'd9, 4'd10, 4'd11, 4'd0, 4'd1, 4'd2, 4'd7, 4'd9, 4'd10,
    4'd11, 4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd10, 4'd3, 4'd9, 4'd4, 4'd10, 4'd5, 4'd11,
    4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
  };

  // Q2.30 product, rounded half up
  function automatic coef_t mul30(input coef_t a, input coef_t b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< 29);
    return p[63:30];
  endfunction

  // Clamp to the 48-bit entry range
  function automatic entry_t sat48(input logic signed [63:0] v);
    entry_t res;
    if (v > SAT_MAX) begin
      res = SAT_MAX[47:0];
    end else if (v < SAT_MIN) begin
      res = SAT_MIN[47:0];
    end else begin
      res = v[47:0];
    end
    return res;
  endfunction

endpackage

>>> sv/ekf_mj_trig.sv
// Pipelined angle formation, range reduction and sine/cosine series for three angles.
module ekf_mj_trig import ekf_mj_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  in_word_t    in_word,
  input  logic [15:0] time_step,
  output logic        out_vld,
  output pos_t        out_pos,
  output sincos_t     out_sc
);

  typedef struct packed {
    logic [31:0]        a2;
    logic [32:0]        ts;
    logic [32:0]        tc;
    logic signed [34:0] sacc;
    logic signed [34:0] cacc;
    logic [1:0]         quad;
    logic               rneg;
    logic               neg;
  } trig_st_t;

  logic [TRIG_LAT-1:0] vld_r;
  pos_t                pos_r [TRIG_LAT];
  logic signed [31:0]  rates [3];
  q30_t                sin_r [3];
  q30_t                cos_r [3];

  assign rates[0] = in_word.roll_rate;
  assign rates[1] = in_word.pitch_rate;
  assign rates[2] = in_word.yaw_rate;

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TRIG_LAT-2:0], in_vld};
    end
  end

  // Position delay line matching the trig latency
  always_ff @(posedge clk) begin
    if (en) begin
      pos_r[0] <= '{pos_x: in_word.pos_x, pos_y: in_word.pos_y, pos_z: in_word.pos_z};
      for (int i = 1; i < TRIG_LAT; i++) begin
        pos_r[i] <= pos_r[i-1];
      end
    end
  end

  for (genvar L = 0; L < 3; L++) begin : g_lane
    logic signed [47:0] ang;
    logic signed [47:0] ang_r;
    logic [47:0]        mag;
    logic [47:0]        v1_r;
    logic               neg1_r;
    logic [39:0]        qprod;
    logic [7:0]         qe2_r;
    logic [47:0]        v2_r;
    logic               neg2_r;
    logic [48:0]        np;
    logic [47:0]        r0;
    logic               ge;
    logic [40:0]        r0c3_r;
    logic [1:0]         quad3_r;
    logic               neg3_r;
    logic signed [41:0] rr;
    logic [40:0]        rmag;
    logic [40:0]        rsum;
    logic [31:0]        a4_r;
    logic               rneg4_r;
    logic [1:0]         quad4_r;
    logic               neg4_r;
    logic [63:0]        aa;
    trig_st_t           st_r [TERM_COUNT+1];
    logic signed [34:0] sr2;
    logic signed [34:0] cr2;
    q30_t               sv;
    q30_t               cv;
    q30_t               sm;
    q30_t               cm;

    // Angle = rate * dt in Q.40
    assign ang = rates[L] * $signed({1'b0, time_step});
    always_ff @(posedge clk) begin
      if (en) begin
        ang_r <= ang;
      end
    end

    // Magnitude plus an eighth turn (pi/4) for rounding of the quadrant count
    assign mag = ang_r[47] ? 48'(-ang_r) : 48'(ang_r);
    always_ff @(posedge clk) begin
      if (en) begin
        v1_r   <= mag + {8'd0, QTR_PI_Q40};
        neg1_r <= ang_r[47];
      end
    end

    // Quotient estimate, low by at most one
    assign qprod = v1_r[47:24] * REDUCE_RECIP;
    always_ff @(posedge clk) begin
      if (en) begin
        qe2_r  <= qprod[39:32];
        v2_r   <= v1_r;
        neg2_r <= neg1_r;
      end
    end

    // Quotient correction
    assign np = qe2_r * HALF_PI_Q40;
    assign r0 = v2_r - np[47:0];
    assign ge = (r0 >= {7'd0, HALF_PI_Q40});
    always_ff @(posedge clk) begin
      if (en) begin
        r0c3_r  <= ge ? 41'(r0 - {7'd0, HALF_PI_Q40}) : r0[40:0];
        quad3_r <= qe2_r[1:0] + {1'b0, ge};
        neg3_r  <= neg2_r;
      end
    end

    // Signed remainder, rounded to Q0.32 magnitude
    assign rr   = $signed({1'b0, r0c3_r}) - $signed({2'b0, QTR_PI_Q40});
    assign rmag = rr[41] ? 41'(-rr) : rr[40:0];
    assign rsum = rmag + 41'd128;
    always_ff @(posedge clk) begin
      if (en) begin
        a4_r    <= rsum[39:8];
        rneg4_r <= rr[41];
        quad4_r <= quad3_r;
        neg4_r  <= neg3_r;
      end
    end

    // Square of the reduced angle; series start values
    assign aa = a4_r * a4_r + 64'h8000_0000;
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[0].a2   <= aa[63:32];
        st_r[0].ts   <= {1'b0, a4_r};
        st_r[0].tc   <= 33'h1_0000_0000;
        st_r[0].sacc <= $signed({3'b0, a4_r});
        st_r[0].cacc <= 35'sh1_0000_0000;
        st_r[0].quad <= quad4_r;
        st_r[0].rneg <= rneg4_r;
        st_r[0].neg  <= neg4_r;
      end
    end

    // One series term per three stages: multiply, reciprocal estimate, correct
    for (genvar K = 1; K <= TERM_COUNT; K++) begin : g_term
      localparam logic [32:0] D_SIN  = 33'((2 * K) * (2 * K + 1));
      localparam logic [32:0] D_COS  = 33'((2 * K - 1) * (2 * K));
      localparam logic [32:0] M_SIN  = 33'((66'd1 << 33) / ((2 * K) * (2 * K + 1)));
      localparam logic [32:0] M_COS  = 33'((66'd1 << 33) / ((2 * K - 1) * (2 * K)));
      localparam logic [32:0] H_SIN  = 33'(((2 * K) * (2 * K + 1)) / 2);
      localparam logic [32:0] H_COS  = 33'(((2 * K - 1) * (2 * K)) / 2);
      localparam bit          DO_SIN = (K <= SIN_TERMS);
      localparam bit          SUB    = (K % 2 == 1);

      trig_st_t    sa_r;
      trig_st_t    sb_r;
      logic [64:0] ps_r;
      logic [64:0] pc_r;
      logic [64:0] rs;
      logic [64:0] rc;
      logic [32:0] xs;
      logic [32:0] xc;
      logic [65:0] es;
      logic [65:0] ec;
      logic [32:0] xs_r;
      logic [32:0] xc_r;
      logic [32:0] qs_r;
      logic [32:0] qc_r;
      logic [32:0] chks;
      logic [32:0] chkc;
      logic [32:0] qs;
      logic [32:0] qc;
      trig_st_t    st_nxt;

      always_ff @(posedge clk) begin
        if (en) begin
          sa_r <= st_r[K-1];
          ps_r <= st_r[K-1].ts * st_r[K-1].a2;
          pc_r <= st_r[K-1].tc * st_r[K-1].a2;
        end
      end

      assign rs = ps_r + 65'h8000_0000;
      assign rc = pc_r + 65'h8000_0000;
      assign xs = rs[64:32] + H_SIN;
      assign xc = rc[64:32] + H_COS;
      assign es = xs * M_SIN;
      assign ec = xc * M_COS;
      always_ff @(posedge clk) begin
        if (en) begin
          sb_r <= sa_r;
          xs_r <= xs;
          xc_r <= xc;
          qs_r <= es[65:33];
          qc_r <= ec[65:33];
        end
      end

      assign chks = xs_r - 33'(qs_r * D_SIN);
      assign chkc = xc_r - 33'(qc_r * D_COS);
      assign qs   = (chks >= D_SIN) ? qs_r + 33'd1 : qs_r;
      assign qc   = (chkc >= D_COS) ? qc_r + 33'd1 : qc_r;

      // Add or subtract the term
      always_comb begin
        st_nxt    = sb_r;
        st_nxt.tc = qc;
        if (SUB) begin
          st_nxt.cacc = sb_r.cacc - $signed({2'b0, qc});
        end else begin
          st_nxt.cacc = sb_r.cacc + $signed({2'b0, qc});
        end
        if (DO_SIN) begin
          st_nxt.ts = qs;
          if (SUB) begin
            st_nxt.sacc = sb_r.sacc - $signed({2'b0, qs});
          end else begin
            st_nxt.sacc = sb_r.sacc + $signed({2'b0, qs});
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st_r[K] <= st_nxt;
        end
      end
    end

    // Round to Q2.30 and apply quadrant and sign
    assign sr2 = st_r[TERM_COUNT].sacc + 35'sd2;
    assign cr2 = st_r[TERM_COUNT].cacc + 35'sd2;
    always_comb begin
      sv = st_r[TERM_COUNT].rneg ? -sr2[33:2] : sr2[33:2];
      cv = cr2[33:2];
      unique case (st_r[TERM_COUNT].quad)
        2'd0: begin sm = sv;  cm = cv;  end
        2'd1: begin sm = cv;  cm = -sv; end
        2'd2: begin sm = -sv; cm = -cv; end
        2'd3: begin sm = -cv; cm = sv;  end
        default: begin sm = sv; cm = cv; end
      endcase
      if (st_r[TERM_COUNT].neg) begin
        sm = -sm;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sin_r[L] <= sm;
        cos_r[L] <= cm;
      end
    end
  end

  assign out_vld   = vld_r[TRIG_LAT-1];
  assign out_pos   = pos_r[TRIG_LAT-1];
  assign out_sc.sr = sin_r[0];
  assign out_sc.cr = cos_r[0];
  assign out_sc.sp = sin_r[1];
  assign out_sc.cp = cos_r[1];
  assign out_sc.sy = sin_r[2];
  assign out_sc.cy = cos_r[2];

endmodule

>>> sv/ekf_mj_rot.sv
// Rotation products, derivative coefficients and the 32 Jacobian entries, pipelined.
module ekf_mj_rot import ekf_mj_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  pos_t        in_pos,
  input  sincos_t     in_sc,
  input  logic [15:0] time_step,
  output logic        out_vld,
  output entry_t      out_vals [ENTRY_COUNT]
);

  logic [ROT_LAT-1:0] vld_r;
  coef_t sr, cr, sp, cp, sy, cy;

  // Stage 1 products
  coef_t cpcy_r, crsy_r, cysp_r, srsy_r, crcy_r, cpsy_r, spsr_r, cysr_r, crsp_r;
  coef_t cpsr_r, cpcr_r, sr1_r, sp1_r, sy1_r, cp1_r, cy1_r;
  pos_t  pos1_r;

  // Stage 2 rotation matrix
  coef_t rm_r [9];
  coef_t sy2_r, cp2_r, cy2_r, spsr2_r, crsp2_r;
  pos_t  pos2_r;

  // Stage 3 coefficients and rotation entries
  coef_t  k_r [8][3];
  entry_t rot3_r [9];
  pos_t   pos3_r;

  // Stage 4 and 5
  logic signed [43:0] pr_r [8][3];
  entry_t             rot4_r [9];
  logic signed [45:0] s_r [8];
  entry_t             rot5_r [9];

  logic signed [31:0] posv [3];
  logic signed [65:0] full [8][3];
  entry_t             vals_nxt [ENTRY_COUNT];
  entry_t             vals_r [ENTRY_COUNT];
  entry_t             dtq;
  logic signed [63:0] dv [8];
  entry_t             dval [8];

  assign sr = 34'(in_sc.sr);
  assign cr = 34'(in_sc.cr);
  assign sp = 34'(in_sc.sp);
  assign cp = 34'(in_sc.cp);
  assign sy = 34'(in_sc.sy);
  assign cy = 34'(in_sc.cy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROT_LAT-2:0], in_vld};
    end
  end

  // First-level trig products
  always_ff @(posedge clk) begin
    if (en) begin
      cpcy_r <= mul30(cp, cy);
      crsy_r <= mul30(cr, sy);
      cysp_r <= mul30(cy, sp);
      srsy_r <= mul30(sr, sy);
      crcy_r <= mul30(cr, cy);
      cpsy_r <= mul30(cp, sy);
      spsr_r <= mul30(sp, sr);
      cysr_r <= mul30(cy, sr);
      crsp_r <= mul30(cr, sp);
      cpsr_r <= mul30(cp, sr);
      cpcr_r <= mul30(cp, cr);
      sr1_r  <= sr;
      sp1_r  <= sp;
      sy1_r  <= sy;
      cp1_r  <= cp;
      cy1_r  <= cy;
      pos1_r <= in_pos;
    end
  end

  // Rotation matrix, row major
  always_ff @(posedge clk) begin
    if (en) begin
      rm_r[0] <= cpcy_r;
      rm_r[1] <= mul30(cysp_r, sr1_r) - crsy_r;
      rm_r[2] <= srsy_r + mul30(crcy_r, sp1_r);
      rm_r[3] <= cpsy_r;
      rm_r[4] <= crcy_r + mul30(spsr_r, sy1_r);
      rm_r[5] <= mul30(crsp_r, sy1_r) - cysr_r;
      rm_r[6] <= -sp1_r;
      rm_r[7] <= cpsr_r;
      rm_r[8] <= cpcr_r;
      sy2_r   <= sy1_r;
      cp2_r   <= cp1_r;
      cy2_r   <= cy1_r;
      spsr2_r <= spsr_r;
      crsp2_r <= crsp_r;
      pos2_r  <= pos1_r;
    end
  end

  // Derivative coefficients (x, y, z weights) and rounded rotation entries
  always_ff @(posedge clk) begin
    if (en) begin
      k_r[0][0] <= '0;
      k_r[0][1] <= rm_r[2];
      k_r[0][2] <= -rm_r[1];
      k_r[1][0] <= mul30(cy2_r, rm_r[6]);
      k_r[1][1] <= mul30(cy2_r, rm_r[7]);
      k_r[1][2] <= mul30(cy2_r, rm_r[8]);
      k_r[2][0] <= -rm_r[3];
      k_r[2][1] <= -rm_r[4];
      k_r[2][2] <= -rm_r[5];
      k_r[3][0] <= '0;
      k_r[3][1] <= rm_r[5];
      k_r[3][2] <= -rm_r[4];
      k_r[4][0] <= mul30(sy2_r, rm_r[6]);
      k_r[4][1] <= mul30(sy2_r, rm_r[7]);
      k_r[4][2] <= mul30(sy2_r, rm_r[8]);
      k_r[5][0] <= rm_r[0];
      k_r[5][1] <= rm_r[1];
      k_r[5][2] <= rm_r[2];
      k_r[6][0] <= '0;
      k_r[6][1] <= rm_r[8];
      k_r[6][2] <= -rm_r[7];
      k_r[7][0] <= -cp2_r;
      k_r[7][1] <= -spsr2_r;
      k_r[7][2] <= -crsp2_r;
      for (int i = 0; i < 9; i++) begin
        rot3_r[i] <= 48'((rm_r[i] + 34'sd32) >>> 6);
      end
      pos3_r <= pos2_r;
    end
  end

  // Position times coefficient, rounded to Q.24
  assign posv[0] = pos3_r.pos_x;
  assign posv[1] = pos3_r.pos_y;
  assign posv[2] = pos3_r.pos_z;
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      for (int c = 0; c < 3; c++) begin
        full[j][c] = posv[c] * k_r[j][c] + (66'sd1 <<< 21);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 8; j++) begin
        for (int c = 0; c < 3; c++) begin
          pr_r[j][c] <= full[j][c][65:22];
        end
      end
      rot4_r <= rot3_r;
    end
  end

  // Sum of the three weighted terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 8; j++) begin
        s_r[j] <= 46'(pr_r[j][0]) + 46'(pr_r[j][1]) + 46'(pr_r[j][2]);
      end
      rot5_r <= rot4_r;
    end
  end

  // Scale by dt and assemble the entry list
  assign dtq = {24'd0, time_step, 8'd0};
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      dv[j]   = s_r[j] * $signed({1'b0, time_step}) + 64'sd32768;
      dval[j] = sat48(dv[j] >>> 16);
    end
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      vals_nxt[i] = ONE_Q24;
    end
    vals_nxt[0]  = rot5_r[0];
    vals_nxt[1]  = rot5_r[1];
    vals_nxt[2]  = rot5_r[2];
    vals_nxt[3]  = dtq;
    vals_nxt[4]  = dval[0];
    vals_nxt[5]  = dval[1];
    vals_nxt[6]  = dval[2];
    vals_nxt[7]  = rot5_r[3];
    vals_nxt[8]  = rot5_r[4];
    vals_nxt[9]  = rot5_r[5];
    vals_nxt[10] = dtq;
    vals_nxt[11] = dval[3];
    vals_nxt[12] = dval[4];
    vals_nxt[13] = dval[5];
    vals_nxt[14] = rot5_r[6];
    vals_nxt[15] = rot5_r[7];
    vals_nxt[16] = rot5_r[8];
    vals_nxt[17] = dtq;
    vals_nxt[18] = dval[6];
    vals_nxt[19] = dval[7];
    vals_nxt[21] = dtq;
    vals_nxt[23] = dtq;
    vals_nxt[25] = dtq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vals_r <= vals_nxt;
    end
  end

  assign out_vld  = vld_r[ROT_LAT-1];
  assign out_vals = vals_r;

endmodule

>>> sv/ekf_mj_ser.sv
// Serializer: holds an item's 32 entries, sends one word per cycle unless stalled.
module ekf_mj_ser import ekf_mj_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  entry_t    in_vals [ENTRY_COUNT],
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  entry_t           vals_r [ENTRY_COUNT];
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             acc;
  logic             last_ent;
  logic             load;

  assign acc      = busy_r && !out_stall;
  assign last_ent = (cnt_r == CNT_W'(ENTRY_COUNT - 1));
  assign ready    = !busy_r || (acc && last_ent);
  assign load     = in_vld && ready;

  // Entry buffer: load whole item, shift one entry per accepted word
  always_ff @(posedge clk) begin
    if (load) begin
      vals_r <= in_vals;
    end else if (acc) begin
      for (int i = 0; i < ENTRY_COUNT - 1; i++) begin
        vals_r[i] <= vals_r[i+1];
      end
      vals_r[ENTRY_COUNT-1] <= vals_r[ENTRY_COUNT-1];
    end
  end

  // Entry counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else if (load) begin
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (acc) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (last_ent) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign out_valid            = busy_r;
  assign out_word.row         = ENTRY_ROW[cnt_r];
  assign out_word.column      = ENTRY_COL[cnt_r];
  assign out_word.entry_value = vals_r[0];
  assign out_word.last        = last_ent;

  // A new item only lands on an empty buffer or as the final word leaves
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || (acc && last_ent)))
    else $error("serializer loaded over pending entries");

  // Entries advance by exactly one per accepted word
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !last_ent) |=> (busy_r && cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("entry counter skipped");

  // Final word without a waiting item empties the buffer
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_ent && !load) |=> !busy_r)
    else $error("serializer stayed busy after final entry");

endmodule

>>> sv/ekf_motion_jacobian_top.sv
// Top level of the EKF motion Jacobian block.
// Each input word (position, roll/pitch/yaw rates) yields 32 output words, the nonzero
// entries of the 12x12 state-transition Jacobian in row-major order, with last set on
// the 32nd. An accepted input word passes the input register, 31 trig stages, 6 Jacobian
// stages and the serializer load before its first output word. After that one word
// leaves per cycle while out_stall is low; the serializer sends one entry per accepted
// word. The pipeline keeps accepting while earlier items are in flight and only stalls
// the input once its last stage waits on a busy serializer.
// time_step resets to 655 (about 10 ms in Q0.16) and may be written only while idle.
module ekf_motion_jacobian_top import ekf_mj_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  logic [15:0] dt_r;
  logic        pipe_en;
  logic        in_vld_r;
  in_word_t    in_word_r;
  logic        trig_vld;
  pos_t        trig_pos;
  sincos_t     trig_sc;
  logic        rot_vld;
  entry_t      rot_vals [ENTRY_COUNT];
  logic        ser_ready;

  // Time step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= TIME_STEP_RESET;
    end else if (cfg_we) begin
      dt_r <= cfg_wdata;
    end
  end

  // Whole pipeline advances unless its last stage waits on the serializer
  assign pipe_en  = !(rot_vld && !ser_ready);
  assign in_stall = !pipe_en;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (pipe_en) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      in_word_r <= in_word;
    end
  end

  ekf_mj_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_vld    (in_vld_r),
    .in_word   (in_word_r),
    .time_step (dt_r),
    .out_vld   (trig_vld),
    .out_pos   (trig_pos),
    .out_sc    (trig_sc)
  );

  ekf_mj_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_vld    (trig_vld),
    .in_pos    (trig_pos),
    .in_sc     (trig_sc),
    .time_step (dt_r),
    .out_vld   (rot_vld),
    .out_vals  (rot_vals)
  );

  ekf_mj_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (rot_vld),
    .in_vals   (rot_vals),
    .ready     (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
